FILE: rtl/core/hsik_pkg.sv
// Shared types, widths and helpers for the H-bot scissor-lift inverse kinematics.
// Used by the square-root pipeline and the top level; depends on nothing.
`default_nettype none

package hsik_pkg;

    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int CFG_W  = 3;

    localparam logic [CFG_W-1:0] CFG_ALPHA_SCALE   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_BETA_SCALE    = 3'd1;
    localparam logic [CFG_W-1:0] CFG_GAMMA_SCALE   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_HINGE_LENGTH  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_OFFSET = 3'd4;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic               clip;
        logic               unreach;
    } t_side;

    typedef struct packed {
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] gamma;
        logic               unreach;
        logic               clip;
    } t_result;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat s;
        if (v > S32_MAX) begin
            s.clip = 1'b1;
            s.val  = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            s.clip = 1'b1;
            s.val  = 32'sh8000_0000;
        end else begin
            s.clip = 1'b0;
            s.val  = v[31:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsik_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on hsik_pkg for widths and the side-band payload type.
`default_nettype none

module hsik_sqrt_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [hsik_pkg::SQ_W-1:0]    i_radicand,
    input  hsik_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [hsik_pkg::ROOT_W-1:0]  o_root,
    output hsik_pkg::t_side              o_side
);
    import hsik_pkg::*;

    logic [SQ_W-1:0] r_rem  [ROOT_W];
    logic [SQ_W-1:0] r_res  [ROOT_W];
    t_side           r_side [ROOT_W];
    logic            r_v    [ROOT_W];

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * gi);

        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        t_side           side_in;
        logic            v_in;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] n_rem;
        logic [SQ_W-1:0] n_res;

        if (gi == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign res_in  = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[gi-1];
            assign res_in  = r_res[gi-1];
            assign side_in = r_side[gi-1];
            assign v_in    = r_v[gi-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (rem_in >= trial) begin
                n_rem = rem_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_rem = rem_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_en) begin
                r_v[gi] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= n_rem;
                r_res[gi]  <= n_res;
                r_side[gi] <= side_in;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/hbot_scissor_lift_inverse_kinematics.sv
// Top level of the H-bot gantry and scissor-lift inverse kinematics pipeline.
// Depends on hsik_pkg and hsik_sqrt_pipe.
//
// One target position is transferred per clock cycle and one result leaves per
// cycle while the skid entry is free and i_ready is high; the pipeline depth is
// set by the 31-stage square root of the lift radicand, one root bit per stage.
// A two-entry output buffer keeps o_ready registered, so the input side keeps
// taking items while one result waits. Configuration writes take effect at once
// and must only be made while no item is in flight.
`default_nettype none

module hbot_scissor_lift_inverse_kinematics #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hsik_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_x_mm,
    input  logic signed [31:0]            i_y_mm,
    input  logic signed [31:0]            i_z_mm,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_alpha_steps,
    output logic signed [31:0]            o_beta_steps,
    output logic signed [31:0]            o_gamma_steps,
    output logic                          o_unreachable,
    output logic                          o_clipped
);
    import hsik_pkg::*;

    localparam int RX_W = 64 - 2 * FRAC_BITS;
    localparam int DX_W = RX_W + 1;
    localparam int AB_W = DX_W + 1;
    localparam logic [63:0] HALF_XY = 64'd1 << (2 * FRAC_BITS - 1);
    localparam logic [63:0] HALF_G  = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0] HINGE_DEF = 64'd250 << FRAC_BITS;
    localparam logic [30:0] HINGE_RST =
        (HINGE_DEF > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : HINGE_DEF[30:0];

    logic [31:0]        r_alpha_scale;
    logic [31:0]        r_beta_scale;
    logic [31:0]        r_gamma_scale;
    logic [30:0]        r_hinge;
    logic signed [31:0] r_height_offset;

    logic en;

    logic                     r1_v, r1_xs, r1_ys;
    logic [31:0]              r1_xa, r1_ya;
    logic signed [33:0]       r1_h;
    logic                     r2_v, r2_xs, r2_ys;
    logic [63:0]              r2_mx, r2_my;
    logic [32:0]              r2_habs;
    logic                     r3_v, r3_xs, r3_ys, r3_unreach;
    logic [RX_W-1:0]          r3_rx, r3_ry;
    logic [30:0]              r3_hc;
    logic                     r4_v, r4_unreach;
    logic signed [DX_W-1:0]   r4_dx, r4_dy;
    logic [SQ_W-1:0]          r4_ll, r4_hh;
    logic                     r5_v, r5_unreach;
    logic signed [AB_W-1:0]   r5_a, r5_b;
    logic [SQ_W-1:0]          r5_r;
    logic                     r6_v;
    logic [SQ_W-1:0]          r6_r;
    t_side                    r6_side;
    logic                     r7_v;
    logic [62:0]              r7_prod;
    t_side                    r7_side;

    logic [31:0]              n1_xa, n1_ya;
    logic signed [33:0]       n1_h;
    logic [32:0]              n2_habs;
    logic                     n3_unreach;
    logic signed [DX_W-1:0]   n4_dx, n4_dy;
    t_sat                     sat_a, sat_b, sat_g;
    t_side                    n6_side;
    logic                     sq_v;
    logic [ROOT_W-1:0]        sq_root;
    t_side                    sq_side;
    logic [63:0]              g_sum;
    logic [63:0]              g_q;
    t_result                  n_res;

    logic                     r_out_v, r_skid_v;
    t_result                  r_out, r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_scale   <= '0;
            r_beta_scale    <= '0;
            r_gamma_scale   <= '0;
            r_hinge         <= HINGE_RST;
            r_height_offset <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA_SCALE:   r_alpha_scale   <= i_cfg_data;
                CFG_BETA_SCALE:    r_beta_scale    <= i_cfg_data;
                CFG_GAMMA_SCALE:   r_gamma_scale   <= i_cfg_data;
                CFG_HINGE_LENGTH:  r_hinge         <= i_cfg_data[30:0];
                CFG_HEIGHT_OFFSET: r_height_offset <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign en      = ~r_skid_v;
    assign o_ready = en;

    always_comb begin
        n1_xa = i_x_mm[31] ? (~i_x_mm + 32'd1) : i_x_mm;
        n1_ya = i_y_mm[31] ? (~i_y_mm + 32'd1) : i_y_mm;
        n1_h  = 34'($signed({1'b0, r_hinge})) - 34'(i_z_mm) + 34'(r_height_offset);
        n2_habs    = r1_h[33] ? 33'(-r1_h) : 33'(r1_h);
        n3_unreach = r2_habs > {2'b00, r_hinge};
        n4_dx = $signed({1'b0, r3_rx});
        if (r3_xs) begin
            n4_dx = -n4_dx;
        end
        n4_dy = $signed({1'b0, r3_ry});
        if (r3_ys) begin
            n4_dy = -n4_dy;
        end
        sat_a = sat32(64'(r5_a));
        sat_b = sat32(64'(r5_b));
        n6_side.alpha   = sat_a.val;
        n6_side.beta    = sat_b.val;
        n6_side.clip    = sat_a.clip | sat_b.clip;
        n6_side.unreach = r5_unreach;
        g_sum = 64'(r7_prod) + HALF_G;
        g_q   = g_sum >> (2 * FRAC_BITS + 1);
        sat_g = sat32($signed(g_q));
        n_res.alpha   = r7_side.alpha;
        n_res.beta    = r7_side.beta;
        n_res.unreach = r7_side.unreach;
        if (r7_side.unreach) begin
            n_res.gamma = '0;
            n_res.clip  = r7_side.clip;
        end else begin
            n_res.gamma = sat_g.val;
            n_res.clip  = r7_side.clip | sat_g.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xs      <= i_x_mm[31];
            r1_ys      <= i_y_mm[31];
            r1_xa      <= n1_xa;
            r1_ya      <= n1_ya;
            r1_h       <= n1_h;
            r2_xs      <= r1_xs;
            r2_ys      <= r1_ys;
            r2_mx      <= 64'(r1_xa) * 64'(r_alpha_scale);
            r2_my      <= 64'(r1_ya) * 64'(r_beta_scale);
            r2_habs    <= n2_habs;
            r3_xs      <= r2_xs;
            r3_ys      <= r2_ys;
            r3_rx      <= RX_W'((r2_mx + HALF_XY) >> (2 * FRAC_BITS));
            r3_ry      <= RX_W'((r2_my + HALF_XY) >> (2 * FRAC_BITS));
            r3_unreach <= n3_unreach;
            r3_hc      <= n3_unreach ? 31'd0 : r2_habs[30:0];
            r4_dx      <= n4_dx;
            r4_dy      <= n4_dy;
            r4_ll      <= SQ_W'(r_hinge) * SQ_W'(r_hinge);
            r4_hh      <= SQ_W'(r3_hc) * SQ_W'(r3_hc);
            r4_unreach <= r3_unreach;
            r5_a       <= AB_W'(r4_dx) + AB_W'(r4_dy);
            r5_b       <= AB_W'(r4_dx) - AB_W'(r4_dy);
            r5_r       <= r4_ll - r4_hh;
            r5_unreach <= r4_unreach;
            r6_r       <= r5_r;
            r6_side    <= n6_side;
            r7_prod    <= 63'(sq_root) * 63'(r_gamma_scale);
            r7_side    <= sq_side;
        end
    end

    hsik_sqrt_pipe u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r6_v),
        .i_radicand (r6_r),
        .i_side     (r6_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (!r_out_v || i_ready) begin
                r_out_v <= r7_v;
            end else if (r7_v) begin
                r_skid_v <= 1'b1;
            end
        end else if (i_ready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_out_v || i_ready) begin
                r_out <= n_res;
            end else if (r7_v) begin
                r_skid <= n_res;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid       = r_out_v;
    assign o_alpha_steps = r_out.alpha;
    assign o_beta_steps  = r_out.beta;
    assign o_gamma_steps = r_out.gamma;
    assign o_unreachable = r_out.unreach;
    assign o_clipped     = r_out.clip;

endmodule

`default_nettype wire
